### sv/csq_pkg.sv
// Shared types and constants for the clocked step sequencer.
// No dependencies; every other file but csq_ram uses this package.
package csq_pkg;

  localparam int NUM_STEPS_DEF = 16;

  // Phase increment divider: 48-bit dividend, 15-bit divisor, two bits a cycle.
  localparam int DIVIDEND_W = 48;
  localparam int DIVISOR_W  = 15;
  localparam int DIV_ITERS  = DIVIDEND_W / 2;
  localparam int ITER_W     = $clog2(DIV_ITERS + 1);
  localparam int PROD_W     = 43;  // tempo (18) x elapsed (25)

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] DIR_FWD  = 2'd0;
  localparam logic [1:0] DIR_BACK = 2'd1;
  localparam logic [1:0] DIR_PING = 2'd2;
  localparam logic [1:0] DIR_RAND = 2'd3;

  localparam logic [1:0] REG_STEP_COUNT = 2'd0;
  localparam logic [1:0] REG_BEATS      = 2'd1;
  localparam logic [1:0] REG_SMOOTHING  = 2'd2;
  localparam logic [1:0] REG_DIRECTION  = 2'd3;

  localparam logic [4:0]  RST_STEP_COUNT = 5'd16;
  localparam logic [11:0] RST_BEATS      = 12'd32;

  localparam logic [17:0] TEMPO_DEFAULT = 18'd30720;  // 120 BPM in 1/256 BPM
  localparam logic [11:0] BEATS_MAX     = 12'd2048;
  localparam logic [31:0] LFSR_SEED     = 32'hDEADBEEF;
  localparam logic [25:0] RECIP_100     = 26'd42949673;  // ceil(2^32 / 100)
  localparam logic [16:0] C_ONE         = 17'd65536;     // 1.0 in Q1.16

  typedef struct packed {
    logic              op;
    logic [24:0]       elapsed_time;
    logic [17:0]       tempo;
    logic [3:0]        step_index;
    logic signed [15:0] step_value;
  } csq_item_t;

  typedef struct packed {
    logic signed [15:0] level;
    logic [3:0]         current_index;
    logic               stepped;
  } csq_result_t;

  typedef struct packed {
    logic [4:0]  step_count;
    logic [11:0] beats_per_step;
    logic [15:0] smoothing;
    logic [1:0]  direction;
  } csq_cfg_t;

  typedef struct packed {
    logic latch;
    logic tbl_wr;
    logic mul;
    logic div_inc;
    logic phase_upd;
    logic mod_start;
    logic mod_take;
    logic pp_step;
    logic rnd_step;
    logic rnd_take;
    logic tbl_rd;
    logic sm_mul;
    logic sm_fin;
    logic load_out;
  } csq_cmd_t;

  typedef struct packed {
    logic       op_write;
    logic       elapsed_zero;
    logic       div_busy;
    logic       wrap;
    logic [1:0] dir;
  } csq_sts_t;

endpackage

### sv/csq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/csq_div.sv
// Restoring divider, two quotient bits per cycle, variable iteration count.
// Depends on csq_pkg for operand widths.
module csq_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [csq_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [csq_pkg::DIVISOR_W-1:0]      divisor,
  input  logic [csq_pkg::ITER_W-1:0]         iters,
  output logic                               busy,
  output logic [csq_pkg::DIVIDEND_W-1:0]     quotient,
  output logic [csq_pkg::DIVISOR_W-1:0]      remainder
);
  import csq_pkg::*;

  logic [ITER_W-1:0]     cnt;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVISOR_W-1:0]  rem1, rem2;
  logic [DIVIDEND_W-1:0] quo1, quo2;
  logic [DIVISOR_W:0]    t1, t2;

  // two dependent shift-subtract steps
  always_comb begin
    t1 = {remainder, quotient[DIVIDEND_W-1]};
    if (t1 >= {1'b0, dsr}) begin
      rem1 = DIVISOR_W'(t1 - {1'b0, dsr});
      quo1 = {quotient[DIVIDEND_W-2:0], 1'b1};
    end else begin
      rem1 = t1[DIVISOR_W-1:0];
      quo1 = {quotient[DIVIDEND_W-2:0], 1'b0};
    end
    t2 = {rem1, quo1[DIVIDEND_W-1]};
    if (t2 >= {1'b0, dsr}) begin
      rem2 = DIVISOR_W'(t2 - {1'b0, dsr});
      quo2 = {quo1[DIVIDEND_W-2:0], 1'b1};
    end else begin
      rem2 = t2[DIVISOR_W-1:0];
      quo2 = {quo1[DIVIDEND_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= iters;
    end else if (busy) begin
      cnt <= cnt - ITER_W'(1);
      if (cnt == ITER_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      quotient  <= quo2;
      remainder <= rem2;
    end
  end

endmodule

### sv/csq_ctrl.sv
// Sequencing state machine: walks one transaction through the datapath.
// Depends on csq_pkg for the command and status structs.
module csq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic              result_ready,
  output logic              result_valid,
  input  csq_pkg::csq_sts_t sts,
  output csq_pkg::csq_cmd_t cmd
);
  import csq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MUL, S_DIVST, S_DIV, S_ADV, S_MOD, S_RAND,
    S_READ, S_SMUL, S_SFIN, S_OUT
  } state_t;

  state_t state, state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.op_write) begin
          cmd.tbl_wr = 1'b1;
          state_next = S_OUT;
        end else if (sts.elapsed_zero) begin
          state_next = S_OUT;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIVST;
      end
      S_DIVST: begin
        cmd.div_inc = 1'b1;
        state_next  = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          cmd.phase_upd = 1'b1;
          state_next    = S_ADV;
        end
      end
      S_ADV: begin
        if (!sts.wrap) begin
          state_next = S_READ;
        end else begin
          case (sts.dir)
            DIR_FWD, DIR_BACK: begin
              cmd.mod_start = 1'b1;
              state_next    = S_MOD;
            end
            DIR_PING: begin
              cmd.pp_step = 1'b1;
              state_next  = S_READ;
            end
            DIR_RAND: begin
              cmd.rnd_step = 1'b1;
              state_next   = S_RAND;
            end
            default: state_next = S_READ;
          endcase
        end
      end
      S_MOD: begin
        if (!sts.div_busy) begin
          cmd.mod_take = 1'b1;
          state_next   = S_READ;
        end
      end
      S_RAND: begin
        cmd.rnd_take = 1'b1;
        state_next   = S_READ;
      end
      S_READ: begin
        cmd.tbl_rd = 1'b1;
        state_next = S_SMUL;
      end
      S_SMUL: begin
        cmd.sm_mul = 1'b1;
        state_next = S_SFIN;
      end
      S_SFIN: begin
        cmd.sm_fin = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!result_valid || result_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

### sv/csq_datapath.sv
// Datapath: phase accumulator, step advance, step table, smoother, result register.
// Depends on csq_pkg, csq_div and csq_ram.
module csq_datapath #(
  parameter int NUM_STEPS = csq_pkg::NUM_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  csq_pkg::csq_cmd_t    cmd,
  input  csq_pkg::csq_cfg_t    cfg,
  input  csq_pkg::csq_item_t   item,
  output csq_pkg::csq_sts_t    sts,
  output csq_pkg::csq_result_t result
);
  import csq_pkg::*;

  localparam int STEP_W   = $clog2(NUM_STEPS);
  localparam int PW       = STEP_W + 1;
  localparam int CMPW     = (PW > 5) ? PW : 5;
  localparam int MOD_ITER = (STEP_W + 2) / 2;
  localparam int MODW     = 2 * MOD_ITER;

  csq_item_t             item_q;
  logic [PROD_W-1:0]     prod;
  logic [31:0]           phase;
  logic                  wrap;
  logic [STEP_W-1:0]     play;
  logic                  bounce;
  logic [31:0]           lfsr;
  logic signed [23:0]    y;
  logic [22:0]           sm_v;
  logic [15:0]           sm_c;
  logic                  rd_valid;
  logic [NUM_STEPS-1:0]  tbl_valid;
  logic signed [40:0]    sm_p1;
  logic signed [41:0]    sm_p2;

  // effective count and step length
  logic [CMPW-1:0]       sc_ext;
  logic [PW-1:0]         n;
  logic [11:0]           beats;
  logic [DIVISOR_W-1:0]  divisor_inc;

  always_comb begin
    sc_ext = CMPW'(cfg.step_count);
    if (sc_ext == '0) begin
      n = PW'(1);
    end else if (sc_ext > CMPW'(NUM_STEPS)) begin
      n = PW'(NUM_STEPS);
    end else begin
      n = PW'(sc_ext);
    end
    if (cfg.beats_per_step == '0) begin
      beats = 12'd1;
    end else if (cfg.beats_per_step > BEATS_MAX) begin
      beats = BEATS_MAX;
    end else begin
      beats = cfg.beats_per_step;
    end
    divisor_inc = DIVISOR_W'(16'(beats) * 16'd15);
  end

  // shared divider: phase increment and step modulo
  logic                   div_start, div_busy;
  logic [DIVIDEND_W-1:0]  div_dividend, div_quo;
  logic [DIVISOR_W-1:0]   div_divisor, div_rem;
  logic [ITER_W-1:0]      div_iters;
  logic [MODW-1:0]        mod_val;

  always_comb begin
    if (cfg.direction == DIR_BACK) begin
      mod_val = MODW'(play) + MODW'(n) - MODW'(1);
    end else begin
      mod_val = MODW'(play) + MODW'(1);
    end
    div_start = cmd.div_inc | cmd.mod_start;
    if (cmd.mod_start) begin
      div_dividend = DIVIDEND_W'(mod_val) << (DIVIDEND_W - MODW);
      div_divisor  = DIVISOR_W'(n);
      div_iters    = ITER_W'(MOD_ITER);
    end else begin
      div_dividend = {prod, 5'b0};
      div_divisor  = divisor_inc;
      div_iters    = ITER_W'(DIV_ITERS);
    end
  end

  csq_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .iters     (div_iters),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  logic [DIVIDEND_W:0] psum;
  assign psum = (DIVIDEND_W + 1)'(phase) + (DIVIDEND_W + 1)'(div_quo);

  // ping-pong move
  logic [PW-1:0]     p_inc;
  logic [STEP_W-1:0] pp_play;
  logic              pp_bounce;

  always_comb begin
    p_inc     = PW'(play) + PW'(1);
    pp_play   = play;
    pp_bounce = bounce;
    if (bounce) begin
      if (p_inc >= n) begin
        pp_play   = (n >= PW'(2)) ? STEP_W'(n - PW'(2)) : '0;
        pp_bounce = 1'b0;
      end else begin
        pp_play = STEP_W'(p_inc);
      end
    end else if (play == '0) begin
      pp_play   = (n > PW'(1)) ? STEP_W'(1) : '0;
      pp_bounce = 1'b1;
    end else begin
      pp_play = play - STEP_W'(1);
    end
  end

  // xorshift32 (13, 17, 5) and random index
  logic [31:0]        lx1, lx2, lfsr_next;
  logic [32+PW-1:0]   rprod;

  always_comb begin
    lx1       = lfsr ^ (lfsr << 13);
    lx2       = lx1 ^ (lx1 >> 17);
    lfsr_next = lx2 ^ (lx2 << 5);
    rprod     = (32 + PW)'(lfsr) * (32 + PW)'(n);
  end

  // step table
  logic                tbl_we;
  logic [STEP_W-1:0]   waddr;
  logic [15:0]         wdata, rdata;

  always_comb begin
    tbl_we = cmd.tbl_wr && (int'(item_q.step_index) < NUM_STEPS);
    waddr  = STEP_W'(item_q.step_index);
    if (item_q.step_value == -16'sd32768) begin
      wdata = -16'sd32767;
    end else begin
      wdata = item_q.step_value;
    end
  end

  csq_ram #(
    .WIDTH (16),
    .DEPTH (NUM_STEPS)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.tbl_rd),
    .raddr (play),
    .rdata (rdata)
  );

  // smoother: y = (y*c + x*(1-c) + 0.5) >> 16
  logic signed [23:0] x_val;
  logic [16:0]        c_comp;
  logic signed [42:0] sm_sum;
  logic [48:0]        c_prod;

  always_comb begin
    x_val  = rd_valid ? {rdata, 8'h00} : '0;
    c_comp = C_ONE - 17'(sm_c);
    sm_sum = 43'(sm_p1) + 43'(sm_p2) + 43'sd32768;
    c_prod = 49'(sm_v) * 49'(RECIP_100);
  end

  // held level: round Q1.23 to Q1.15 and clamp
  logic signed [24:0] yr;
  logic signed [16:0] lt;
  logic signed [15:0] lvl;

  always_comb begin
    yr = 25'(y) + 25'sd128;
    lt = $signed(yr[24:8]);
    if (lt > 17'sd32767) begin
      lvl = 16'sd32767;
    end else if (lt < -17'sd32767) begin
      lvl = -16'sd32767;
    end else begin
      lvl = 16'(lt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      wrap      <= 1'b0;
      play      <= '0;
      bounce    <= 1'b1;
      lfsr      <= LFSR_SEED;
      y         <= '0;
      tbl_valid <= '0;
    end else begin
      if (cmd.latch) begin
        wrap <= 1'b0;
      end
      if (cmd.phase_upd) begin
        phase <= psum[31:0];
        wrap  <= |psum[DIVIDEND_W:32];
      end
      if (cmd.mod_take) begin
        play <= STEP_W'(div_rem);
      end
      if (cmd.pp_step) begin
        play   <= pp_play;
        bounce <= pp_bounce;
      end
      if (cmd.rnd_step) begin
        lfsr <= lfsr_next;
      end
      if (cmd.rnd_take) begin
        play <= rprod[32 +: STEP_W];
      end
      if (cmd.sm_fin) begin
        y <= (cfg.smoothing == '0) ? x_val : sm_sum[39:16];
      end
      if (tbl_we) begin
        tbl_valid[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_q <= item;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(((item_q.tempo == '0) ? TEMPO_DEFAULT : item_q.tempo))
              * PROD_W'(item_q.elapsed_time);
    end
    // coefficient c = (s*99 + 50) / 100, refreshed every cycle
    sm_v <= 23'(23'(cfg.smoothing) * 23'd99) + 23'd50;
    sm_c <= c_prod[47:32];
    if (cmd.tbl_rd) begin
      rd_valid <= tbl_valid[play];
    end
    if (cmd.sm_mul) begin
      sm_p1 <= y * $signed({1'b0, sm_c});
      sm_p2 <= x_val * $signed({1'b0, c_comp});
    end
    if (cmd.load_out) begin
      result.level         <= lvl;
      result.current_index <= 4'(play);
      result.stepped       <= wrap;
    end
  end

  always_comb begin
    sts.op_write     = (item_q.op == OP_WRITE);
    sts.elapsed_zero = (item_q.elapsed_time == '0);
    sts.div_busy     = div_busy;
    sts.wrap         = wrap;
    sts.dir          = cfg.direction;
  end

endmodule

### sv/clocked_step_sequencer.sv
// Top level of the clocked step sequencer: config registers and unit wiring.
// Depends on csq_pkg, csq_ctrl and csq_datapath.
//
// Usage:
//   item channel (item_valid/item_ready/item): one transaction per tick or
//   table write. op = tick advances a Q0.32 phase by tempo*elapsed/(60*step
//   length); on wrap the step moves forward, backward, ping-pong or random.
//   op = write stores a clamped Q1.15 value into the step table.
//   result channel (result_valid/result_ready/result): exactly one result per
//   transaction, in order: level (Q1.15), current_index, stepped.
//   Order: a tick with nonzero elapsed time passes decode, the multiply,
//   the radix-4 phase divider, the step advance, a step modulo on the
//   shared divider for a forward or backward wrap or a random draw for a
//   random one, the table read and the smoother. Writes and zero-length
//   ticks go from decode to output; item_ready is high only while idle.
//   The result sits in an output register: a new transaction is accepted
//   while it waits, and processing holds in its final cycle only if the
//   previous result is still not taken.
//   Reset (rst, synchronous): phase 0, step 0, ping-pong direction up,
//   smoother 0, random seed 0xDEADBEEF, whole table reads as zero, and the
//   registers go to count 16, step length 32, no smoothing, forward.
//   APB registers (byte address 4*i): step_count, beats_per_step,
//   smoothing, direction. Write them only while no transaction is in flight.
module clocked_step_sequencer #(
  parameter int NUM_STEPS = csq_pkg::NUM_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          item_valid,
  output logic                          item_ready,
  input  csq_pkg::csq_item_t            item,
  // result channel
  output logic                          result_valid,
  input  logic                          result_ready,
  output csq_pkg::csq_result_t          result,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csq_pkg::PADDR_W-1:0]   paddr,
  input  logic [csq_pkg::PDATA_W-1:0]   pwdata,
  output logic [csq_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import csq_pkg::*;

  csq_cfg_t cfg;
  csq_cmd_t cmd;
  csq_sts_t sts;

  // zero wait states
  assign pready = 1'b1;

  // register write on the access phase; index is the word address
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_count     <= RST_STEP_COUNT;
      cfg.beats_per_step <= RST_BEATS;
      cfg.smoothing      <= '0;
      cfg.direction      <= DIR_FWD;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_STEP_COUNT: cfg.step_count     <= pwdata[4:0];
        REG_BEATS:      cfg.beats_per_step <= pwdata[11:0];
        REG_SMOOTHING:  cfg.smoothing      <= pwdata[15:0];
        REG_DIRECTION:  cfg.direction      <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    case (paddr[3:2])
      REG_STEP_COUNT: prdata = PDATA_W'(cfg.step_count);
      REG_BEATS:      prdata = PDATA_W'(cfg.beats_per_step);
      REG_SMOOTHING:  prdata = PDATA_W'(cfg.smoothing);
      REG_DIRECTION:  prdata = PDATA_W'(cfg.direction);
      default:        prdata = '0;
    endcase
  end

  // sequencing: one transaction through the datapath at a time
  csq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .sts          (sts),
    .cmd          (cmd)
  );

  // phase, step state, table, smoother and the result register
  csq_datapath #(
    .NUM_STEPS (NUM_STEPS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .cfg    (cfg),
    .item   (item),
    .sts    (sts),
    .result (result)
  );

endmodule

### sv/csq_checker.sv
// Port-level assertions for the clocked step sequencer, bound to the top level.
// Depends on csq_pkg and clocked_step_sequencer.
module csq_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_ready,
  input logic                 result_valid,
  input logic                 result_ready,
  input csq_pkg::csq_result_t result
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  // one transaction in flight: no acceptance in the cycle after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item accepted back to back");

  // level is clamped to the symmetric Q1.15 range
  a_level_clamped: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.level != 16'sh8000)
    else $error("level outside clamp range");

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind clocked_step_sequencer csq_checker u_csq_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
